@@ src/dlcg_pkg.sv @@
// Package: shared constants and register indexes for the distance link contact generator.
`timescale 1ns / 1ps
`default_nettype none
package dlcg_pkg;
   localparam int COORD_WIDTH_DEF  = 32;
   localparam int NORMAL_WIDTH_DEF = 16;
   localparam int TAG_WIDTH        = 16;
   localparam int DEPTH_WIDTH      = 32;
   localparam int BOUNCE_WIDTH     = 16;
   localparam int KIND_WIDTH       = 2;
   localparam int CSR_INDEX_WIDTH  = 3;

   localparam logic [DEPTH_WIDTH-1:0] REST_RESET = 32'h0001_0000;

   // bit 0 of link_kind selects rod, bit 1 selects anchor
   localparam int KIND_ROD_BIT    = 0;
   localparam int KIND_ANCHOR_BIT = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_LINK_KIND     = 3'd0,
      REG_REST_LENGTH   = 3'd1,
      REG_BOUNCE_FACTOR = 3'd2,
      REG_ANCHOR_X      = 3'd3,
      REG_ANCHOR_Y      = 3'd4,
      REG_ANCHOR_Z      = 3'd5
   } reg_index_type;
endpackage
`default_nettype wire

@@ src/dlcg_if.sv @@
// Interfaces: request (position pair) and response (contact) channels.
`timescale 1ns / 1ps
`default_nettype none
interface dlcg_req_if #(
   parameter int COORD_WIDTH = dlcg_pkg::COORD_WIDTH_DEF
);
   logic                            valid;
   logic                            ready;
   logic [dlcg_pkg::TAG_WIDTH-1:0]  link_tag;
   logic signed [COORD_WIDTH-1:0]   first_x;
   logic signed [COORD_WIDTH-1:0]   first_y;
   logic signed [COORD_WIDTH-1:0]   first_z;
   logic signed [COORD_WIDTH-1:0]   second_x;
   logic signed [COORD_WIDTH-1:0]   second_y;
   logic signed [COORD_WIDTH-1:0]   second_z;

   modport source (output valid, link_tag, first_x, first_y, first_z,
                   second_x, second_y, second_z, input ready);
   modport sink   (input valid, link_tag, first_x, first_y, first_z,
                   second_x, second_y, second_z, output ready);
endinterface

interface dlcg_rsp_if #(
   parameter int NORMAL_WIDTH = dlcg_pkg::NORMAL_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic [dlcg_pkg::TAG_WIDTH-1:0]    contact_tag;
   logic                              with_anchor;
   logic signed [NORMAL_WIDTH-1:0]    normal_x;
   logic signed [NORMAL_WIDTH-1:0]    normal_y;
   logic signed [NORMAL_WIDTH-1:0]    normal_z;
   logic [dlcg_pkg::DEPTH_WIDTH-1:0]  depth;
   logic [dlcg_pkg::BOUNCE_WIDTH-1:0] contact_restitution;

   modport source (output valid, contact_tag, with_anchor, normal_x, normal_y, normal_z,
                   depth, contact_restitution, input ready);
   modport sink   (input valid, contact_tag, with_anchor, normal_x, normal_y, normal_z,
                   depth, contact_restitution, output ready);
endinterface
`default_nettype wire

@@ src/distance_link_contact_generator.sv @@
// Top level: pipelined distance, link test and contact generation.
`timescale 1ns / 1ps
`default_nettype none
// One link item is accepted per cycle unless the response stalls. Each item runs
// through a fixed pipeline: difference, square, sum, one stage per root bit of
// the square root (COORD_WIDTH+1 stages), one stage per quotient bit of the three
// parallel normal divisions (NORMAL_WIDTH-1 stages), then the link test into the
// output register. Any response stall freezes the whole pipeline. Items that do
// not violate their link give no contact, but a cable at exactly its rest length
// gives one of zero depth. Registers are sampled live, so write them only while
// the pipeline is empty.
module distance_link_contact_generator #(
   parameter int COORD_WIDTH  = dlcg_pkg::COORD_WIDTH_DEF,
   parameter int NORMAL_WIDTH = dlcg_pkg::NORMAL_WIDTH_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   dlcg_req_if.sink                                     req,
   dlcg_rsp_if.source                                   rsp,
   input  wire logic                                    csr_we,
   input  wire logic [dlcg_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] csr_wdata
);
   localparam int CW   = COORD_WIDTH;
   localparam int SW   = 2*CW + 2;
   localparam int RW   = CW + 1;
   localparam int REMW = RW + 2;
   localparam int NF   = NORMAL_WIDTH - 2;
   localparam int ND   = NF + 1;
   localparam int DW   = ((RW > dlcg_pkg::DEPTH_WIDTH) ? RW : dlcg_pkg::DEPTH_WIDTH) + 1;
   localparam int TW   = dlcg_pkg::TAG_WIDTH;

   typedef struct packed {
      logic [TW-1:0] tag;
      logic [2:0]    neg;
      logic [CW-1:0] mx;
      logic [CW-1:0] my;
      logic [CW-1:0] mz;
   } carry_type;

   // configuration registers
   logic [dlcg_pkg::KIND_WIDTH-1:0]   kind_ff;
   logic [dlcg_pkg::DEPTH_WIDTH-1:0]  rest_ff;
   logic [dlcg_pkg::BOUNCE_WIDTH-1:0] bounce_ff;
   logic [CW-1:0]                     anc_x_ff, anc_y_ff, anc_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= '0;
         rest_ff   <= dlcg_pkg::REST_RESET;
         bounce_ff <= '0;
         anc_x_ff  <= '0;
         anc_y_ff  <= '0;
         anc_z_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            dlcg_pkg::REG_LINK_KIND:
               kind_ff <= csr_wdata[dlcg_pkg::KIND_WIDTH-1:0];
            dlcg_pkg::REG_REST_LENGTH:
               rest_ff <= csr_wdata[dlcg_pkg::DEPTH_WIDTH-1:0];
            dlcg_pkg::REG_BOUNCE_FACTOR:
               bounce_ff <= csr_wdata[dlcg_pkg::BOUNCE_WIDTH-1:0];
            dlcg_pkg::REG_ANCHOR_X: anc_x_ff <= csr_wdata[CW-1:0];
            dlcg_pkg::REG_ANCHOR_Y: anc_y_ff <= csr_wdata[CW-1:0];
            dlcg_pkg::REG_ANCHOR_Z: anc_z_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   wire logic anchored = kind_ff[dlcg_pkg::KIND_ANCHOR_BIT];
   wire logic rod      = kind_ff[dlcg_pkg::KIND_ROD_BIT];

   logic rsp_valid_ff;
   wire logic adv = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   // stage A: signed differences to magnitude and sign
   logic      a_vld_ff;
   carry_type a_car_ff, a_car_in;
   logic [CW:0] dx, dy, dz;

   always_comb begin
      dx = {anchored ? anc_x_ff[CW-1] : req.second_x[CW-1],
            anchored ? anc_x_ff : req.second_x} - {req.first_x[CW-1], req.first_x};
      dy = {anchored ? anc_y_ff[CW-1] : req.second_y[CW-1],
            anchored ? anc_y_ff : req.second_y} - {req.first_y[CW-1], req.first_y};
      dz = {anchored ? anc_z_ff[CW-1] : req.second_z[CW-1],
            anchored ? anc_z_ff : req.second_z} - {req.first_z[CW-1], req.first_z};
      a_car_in.tag = req.link_tag;
      a_car_in.neg = {dz[CW], dy[CW], dx[CW]};
      a_car_in.mx  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
      a_car_in.my  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
      a_car_in.mz  = dz[CW] ? CW'(-dz) : dz[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (adv) a_vld_ff <= req.valid;
      if (adv) a_car_ff <= a_car_in;
   end

   // stage B: squares
   logic          b_vld_ff;
   carry_type     b_car_ff;
   logic [2*CW-1:0] sqx_ff, sqy_ff, sqz_ff;

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (adv) b_vld_ff <= a_vld_ff;
      if (adv) begin
         b_car_ff <= a_car_ff;
         sqx_ff   <= a_car_ff.mx * a_car_ff.mx;
         sqy_ff   <= a_car_ff.my * a_car_ff.my;
         sqz_ff   <= a_car_ff.mz * a_car_ff.mz;
      end
   end

   // stage C: sum of squares
   logic          c_vld_ff;
   carry_type     c_car_ff;
   logic [SW-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (adv) c_vld_ff <= b_vld_ff;
      if (adv) begin
         c_car_ff <= b_car_ff;
         sum_ff   <= SW'(sqx_ff) + SW'(sqy_ff) + SW'(sqz_ff);
      end
   end

   // square root: one root bit per stage
   logic            s_vld_ff  [RW];
   carry_type       s_car_ff  [RW];
   logic [SW-1:0]   s_x_ff    [RW];
   logic [REMW-1:0] s_rem_ff  [RW];
   logic [RW-1:0]   s_root_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      logic            p_vld;
      carry_type       p_car;
      logic [SW-1:0]   p_x;
      logic [REMW-1:0] p_rem, rem_in, trial;
      logic [RW-1:0]   p_root;
      logic            take;
      if (k == 0) begin : g_first
         assign p_vld  = c_vld_ff;
         assign p_car  = c_car_ff;
         assign p_x    = sum_ff;
         assign p_rem  = '0;
         assign p_root = '0;
      end else begin : g_next
         assign p_vld  = s_vld_ff[k-1];
         assign p_car  = s_car_ff[k-1];
         assign p_x    = s_x_ff[k-1];
         assign p_rem  = s_rem_ff[k-1];
         assign p_root = s_root_ff[k-1];
      end
      assign rem_in = {p_rem[REMW-3:0], p_x[SW-1:SW-2]};
      assign trial  = {p_root, 2'b01};
      assign take   = rem_in >= trial;

      always_ff @(posedge clock) begin
         if (reset) s_vld_ff[k] <= 1'b0;
         else if (adv) s_vld_ff[k] <= p_vld;
         if (adv) begin
            s_car_ff[k]  <= p_car;
            s_x_ff[k]    <= {p_x[SW-3:0], 2'b00};
            s_rem_ff[k]  <= take ? rem_in - trial : rem_in;
            s_root_ff[k] <= {p_root[RW-2:0], take};
         end
      end
   end

   // normal divisions: one quotient bit per stage, three lanes
   logic          d_vld_ff [ND];
   carry_type     d_car_ff [ND];
   logic [RW-1:0] d_len_ff [ND];
   logic [RW:0]   d_rem_ff [ND][3];
   logic [ND-1:0] d_q_ff   [ND][3];

   for (genvar j = 0; j < ND; j++) begin : g_div
      logic          p_vld;
      carry_type     p_car;
      logic [RW-1:0] p_len;
      logic [RW:0]   p_rem [3];
      logic [ND-1:0] p_q   [3];
      if (j == 0) begin : g_first
         assign p_vld    = s_vld_ff[RW-1];
         assign p_car    = s_car_ff[RW-1];
         assign p_len    = s_root_ff[RW-1];
         assign p_rem[0] = (RW+1)'(s_car_ff[RW-1].mx);
         assign p_rem[1] = (RW+1)'(s_car_ff[RW-1].my);
         assign p_rem[2] = (RW+1)'(s_car_ff[RW-1].mz);
         assign p_q[0]   = '0;
         assign p_q[1]   = '0;
         assign p_q[2]   = '0;
      end else begin : g_next
         assign p_vld = d_vld_ff[j-1];
         assign p_car = d_car_ff[j-1];
         assign p_len = d_len_ff[j-1];
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign p_rem[l] = {d_rem_ff[j-1][l][RW-1:0], 1'b0};
            assign p_q[l]   = d_q_ff[j-1][l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) d_vld_ff[j] <= 1'b0;
         else if (adv) d_vld_ff[j] <= p_vld;
         if (adv) begin
            d_car_ff[j] <= p_car;
            d_len_ff[j] <= p_len;
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_step
         wire logic ge = p_rem[l] >= {1'b0, p_len};
         always_ff @(posedge clock) begin
            if (adv) begin
               d_rem_ff[j][l] <= ge ? p_rem[l] - {1'b0, p_len} : p_rem[l];
               d_q_ff[j][l]   <= {p_q[l][ND-2:0], ge};
            end
         end
      end
   end

   // link test and output register
   logic [DW-1:0] len_w, rest_w, dep_w;
   logic          emit, flip;
   logic [NORMAL_WIDTH-1:0] nrm [3];
   logic [dlcg_pkg::DEPTH_WIDTH-1:0] dep_sat;

   always_comb begin
      len_w = DW'(d_len_ff[ND-1]);
      rest_w = DW'(rest_ff);
      flip = 1'b0;
      dep_w = len_w - rest_w;
      if (!rod) begin
         emit = len_w >= rest_w;
      end else if (len_w > rest_w) begin
         emit = 1'b1;
      end else begin
         emit  = len_w != rest_w;
         flip  = 1'b1;
         dep_w = rest_w - len_w;
      end
      dep_sat = (dep_w > DW'({dlcg_pkg::DEPTH_WIDTH{1'b1}})) ?
                {dlcg_pkg::DEPTH_WIDTH{1'b1}} : dep_w[dlcg_pkg::DEPTH_WIDTH-1:0];
      for (int l = 0; l < 3; l++) begin
         if (len_w == '0) nrm[l] = '0;
         else if (d_car_ff[ND-1].neg[l] != flip)
            nrm[l] = NORMAL_WIDTH'(-NORMAL_WIDTH'(d_q_ff[ND-1][l]));
         else nrm[l] = NORMAL_WIDTH'(d_q_ff[ND-1][l]);
      end
   end

   logic [TW-1:0]                     tag_ff;
   logic                              anc_ff;
   logic [NORMAL_WIDTH-1:0]           nx_ff, ny_ff, nz_ff;
   logic [dlcg_pkg::DEPTH_WIDTH-1:0]  dep_ff;
   logic [dlcg_pkg::BOUNCE_WIDTH-1:0] rest_out_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= d_vld_ff[ND-1] && emit;
      if (adv) begin
         tag_ff      <= d_car_ff[ND-1].tag;
         anc_ff      <= anchored;
         nx_ff       <= nrm[0];
         ny_ff       <= nrm[1];
         nz_ff       <= nrm[2];
         dep_ff      <= dep_sat;
         rest_out_ff <= rod ? '0 : bounce_ff;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.contact_tag         = tag_ff;
   assign rsp.with_anchor         = anc_ff;
   assign rsp.normal_x            = nx_ff;
   assign rsp.normal_y            = ny_ff;
   assign rsp.normal_z            = nz_ff;
   assign rsp.depth               = dep_ff;
   assign rsp.contact_restitution = rest_out_ff;
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the distance link contact generator: directed and random links, self-checking.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   localparam int CW = dlcg_pkg::COORD_WIDTH_DEF;
   localparam int NW = dlcg_pkg::NORMAL_WIDTH_DEF;
   localparam int TGW = dlcg_pkg::TAG_WIDTH;
   localparam int PIPE_DRAIN = dlcg_pkg::COORD_WIDTH_DEF + dlcg_pkg::NORMAL_WIDTH_DEF + 12;
   localparam int IDLE_LIMIT = 4000;
   localparam logic [dlcg_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [dlcg_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_HI = 3'd7;
   localparam logic [1:0] KIND_CABLE = 2'd0, KIND_ROD = 2'd1;
   localparam logic [1:0] KIND_CABLE_ANCHOR = 2'd2, KIND_ROD_ANCHOR = 2'd3;
   localparam logic [31:0] ONE = 32'h0001_0000;

   typedef struct packed {
      logic [TGW-1:0] tag;
      logic signed [CW-1:0] fx, fy, fz, sx, sy, sz;
   } link_type;

   typedef struct packed {
      logic [TGW-1:0]                    tag;
      logic                              anchored;
      logic signed [NW-1:0]              nx, ny, nz;
      logic [dlcg_pkg::DEPTH_WIDTH-1:0]  depth;
      logic [dlcg_pkg::BOUNCE_WIDTH-1:0] restitution;
   } contact_type;

   logic clock, reset;
   logic csr_we;
   logic [dlcg_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [31:0] csr_wdata;

   dlcg_req_if #(.COORD_WIDTH(CW)) req ();
   dlcg_rsp_if #(.NORMAL_WIDTH(NW)) rsp ();

   distance_link_contact_generator #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // mirror of the register file
   logic [1:0]                        kind_m;
   logic [31:0]                       rest_m;
   logic [dlcg_pkg::BOUNCE_WIDTH-1:0] bounce_m;
   logic signed [CW-1:0]              anchor_m [3];

   contact_type pending_contacts [$];
   int errors = 0;
   bit quiet = 0;
   int idle_cycles = 0;
   int stall_left = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // length of a vector given as magnitudes: floor of square root of an exact sum
   function automatic logic [63:0] vector_length(input logic [127:0] sum);
      logic [63:0] root, trial;
      root = 0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if ({64'd0, trial} * {64'd0, trial} <= sum) root = trial;
      end
      return root;
   endfunction

   function automatic bit predict_contact(input link_type it, output contact_type c);
      logic signed [CW-1:0] far_end [3], near_end [3];
      logic signed [CW:0] d;
      logic [63:0] mag [3], len, dep, q;
      logic [127:0] sum;
      bit neg [3], flip, rod, anchored;
      anchored = kind_m[dlcg_pkg::KIND_ANCHOR_BIT];
      rod = kind_m[dlcg_pkg::KIND_ROD_BIT];
      near_end = '{it.fx, it.fy, it.fz};
      if (anchored) far_end = anchor_m;
      else far_end = '{it.sx, it.sy, it.sz};
      sum = 0;
      flip = 0;
      for (int i = 0; i < 3; i++) begin
         d = $signed({far_end[i][CW-1], far_end[i]}) - $signed({near_end[i][CW-1], near_end[i]});
         neg[i] = d < 0;
         mag[i] = neg[i] ? 64'(-d) : 64'(d);
         sum += {64'd0, mag[i]} * {64'd0, mag[i]};
      end
      len = vector_length(sum);
      if (!rod) begin
         if (len < rest_m) return 0;
         dep = len - rest_m;
      end else if (len > rest_m) begin
         dep = len - rest_m;
      end else if (len < rest_m) begin
         dep = rest_m - len;
         flip = 1;
      end else begin
         return 0;
      end
      c.tag = it.tag;
      c.anchored = anchored;
      for (int i = 0; i < 3; i++) begin
         q = (len == 0) ? 64'd0 : (mag[i] << (NW - 2)) / len;
         q = (neg[i] != flip) ? -q : q;
         if (i == 0) c.nx = q[NW-1:0];
         else if (i == 1) c.ny = q[NW-1:0];
         else c.nz = q[NW-1:0];
      end
      c.depth = (dep > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dep[31:0];
      c.restitution = rod ? '0 : bounce_m;
      return 1;
   endfunction

   // drive one item, idling first at random
   task automatic send_link(input link_type it);
      contact_type c;
      int gap;
      gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         @(negedge clock) req.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req.valid <= 1'b1;
      req.link_tag <= it.tag;
      req.first_x <= it.fx;
      req.first_y <= it.fy;
      req.first_z <= it.fz;
      req.second_x <= it.sx;
      req.second_y <= it.sy;
      req.second_z <= it.sz;
      do @(posedge clock); while (!req.ready);
      if (predict_contact(it, c)) pending_contacts.push_back(c);
   endtask

   task automatic drain();
      @(negedge clock) req.valid <= 1'b0;
      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(input logic [dlcg_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         dlcg_pkg::REG_LINK_KIND:     kind_m = data[1:0];
         dlcg_pkg::REG_REST_LENGTH:   rest_m = data;
         dlcg_pkg::REG_BOUNCE_FACTOR: bounce_m = data[dlcg_pkg::BOUNCE_WIDTH-1:0];
         dlcg_pkg::REG_ANCHOR_X:      anchor_m[0] = data[CW-1:0];
         dlcg_pkg::REG_ANCHOR_Y:      anchor_m[1] = data[CW-1:0];
         dlcg_pkg::REG_ANCHOR_Z:      anchor_m[2] = data[CW-1:0];
         default: ;
      endcase
      @(negedge clock) csr_we <= 1'b0;
   endtask

   function automatic link_type make_link(input logic [31:0] a, b, c, d, e, f);
      link_type it;
      it.tag = TGW'($urandom);
      it.fx = a; it.fy = b; it.fz = c;
      it.sx = d; it.sy = e; it.sz = f;
      return it;
   endfunction

   // coordinates mostly within a few units, sometimes anywhere
   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
   endfunction

   task automatic test_reset_defaults();
      // cable of one unit: below, exactly at, and beyond the rest length
      send_link(make_link(0, 0, 0, ONE / 2, 0, 0));
      send_link(make_link(0, 0, 0, 0, ONE, 0));
      send_link(make_link(0, 0, 0, 0, 0, -2 * ONE));
      send_link(make_link(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      drain();
   endtask

   task automatic test_zero_and_saturation();
      link_type it;
      write_reg(dlcg_pkg::REG_REST_LENGTH, 0);
      it = make_link(5, 5, 5, 5, 5, 5);
      it.tag = 16'hFFFF;
      send_link(it);
      it = make_link(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      it.tag = 16'h0000;
      send_link(it);
      drain();
   endtask

   task automatic test_link_kinds();
      logic [1:0] kinds [4];
      kinds = '{KIND_CABLE, KIND_ROD, KIND_CABLE_ANCHOR, KIND_ROD_ANCHOR};
      // upper bits are garbage and must be masked off
      write_reg(dlcg_pkg::REG_BOUNCE_FACTOR, 32'hABCD_FFFF);
      write_reg(dlcg_pkg::REG_REST_LENGTH, 5 * ONE);
      for (int k = 0; k < 4; k++) begin
         write_reg(dlcg_pkg::REG_LINK_KIND, 32'hFFFF_FFFC | {30'd0, kinds[k]});
         write_reg(dlcg_pkg::REG_ANCHOR_X, 3 * ONE);
         write_reg(dlcg_pkg::REG_ANCHOR_Y, -4 * ONE);
         write_reg(dlcg_pkg::REG_ANCHOR_Z, 0);
         send_link(make_link(0, 0, 0, 3 * ONE, 4 * ONE, 0));
         send_link(make_link(0, 0, 0, ONE, ONE, ONE));
         send_link(make_link(0, 0, 0, -6 * ONE, 0, 0));
         send_link(make_link(ONE, ONE, ONE, ONE, ONE, ONE));
         drain();
      end
      // writes to unused indexes are dropped
      write_reg(REG_UNUSED_LO, 32'h1234_5678);
      write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
      send_link(make_link(0, 0, 0, 0, 7 * ONE, 0));
      drain();
   endtask

   task automatic randomize_regs();
      int pick;
      write_reg(dlcg_pkg::REG_LINK_KIND, $urandom);
      pick = $urandom_range(0, 5);
      write_reg(dlcg_pkg::REG_REST_LENGTH, pick == 0 ? 32'd0 : pick == 1 ? 32'hFFFF_FFFF :
                pick == 2 ? $urandom : $urandom_range(0, 6 * ONE));
      pick = $urandom_range(0, 3);
      write_reg(dlcg_pkg::REG_BOUNCE_FACTOR,
                pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF : $urandom);
      write_reg(dlcg_pkg::REG_ANCHOR_X, rand_coord());
      write_reg(dlcg_pkg::REG_ANCHOR_Y, rand_coord());
      write_reg(dlcg_pkg::REG_ANCHOR_Z, rand_coord());
   endtask

   task automatic test_random_links(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         randomize_regs();
         for (int n = 0; n < per_phase; n++)
            send_link(make_link(rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord()));
         drain();
      end
   endtask

   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      contact_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.contact_tag, rsp.with_anchor, rsp.normal_x, rsp.normal_y,
                 rsp.normal_z, rsp.depth, rsp.contact_restitution};
         if (pending_contacts.size() == 0) begin
            errors++;
            $display("%0t: unexpected contact %h", $time, got);
         end else begin
            want = pending_contacts.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: contact mismatch expected tag %h anc %b n %0d %0d %0d d %h r %h",
                        $time, want.tag, want.anchored, want.nx, want.ny, want.nz,
                        want.depth, want.restitution);
               $display("%0t:                  actual tag %h anc %b n %0d %0d %0d d %h r %h",
                        $time, got.tag, got.anchored, got.nx, got.ny, got.nz,
                        got.depth, got.restitution);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = dlcg_pkg::REG_LINK_KIND;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.link_tag = '0;
      req.first_x = '0; req.first_y = '0; req.first_z = '0;
      req.second_x = '0; req.second_y = '0; req.second_z = '0;
      rsp.ready = 1'b1;
      kind_m = KIND_CABLE;
      rest_m = dlcg_pkg::REST_RESET;
      bounce_m = '0;
      anchor_m = '{0, 0, 0};
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_reset_defaults();
      test_zero_and_saturation();
      test_link_kinds();
      test_random_links(10, 30);
      quiet = 1;
      test_random_links(2, 50);

      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
